// ===== hw/rtl/fsfe_pkg.sv =====
// Shared constants and types for the framebuffer shape fill engine.
// Used by the frame store, the squaring unit and the top level; no dependencies.
`timescale 1ns / 1ps

package fsfe_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 64;
   localparam int SCREEN_HEIGHT_DEFAULT = 64;

   // Widest row address the store interface carries (screens up to 256 rows).
   localparam int ROW_ADDR_W = 8;

   // Signed distance width in sixteenths of a pixel and width of its square.
   localparam int DIST_W = 14;
   localparam int SQ_W   = 27;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_RECT   = 2'd1;
   localparam logic [1:0] CMD_CIRCLE = 2'd2;
   localparam logic [1:0] CMD_SHOW   = 2'd3;

   localparam logic [6:0] CHAR_BOTH   = 7'h43;
   localparam logic [6:0] CHAR_TOP    = 7'h5E;
   localparam logic [6:0] CHAR_BOTTOM = 7'h5F;
   localparam logic [6:0] CHAR_NONE   = 7'h20;

   typedef struct packed {
      logic                  rd_en;
      logic [ROW_ADDR_W-1:0] rd_row;
      logic                  wr_en;
      logic [ROW_ADDR_W-1:0] wr_row;
      logic                  clear;
   } store_ctl_type;

endpackage

// ===== hw/rtl/fsfe_frame_store.sv =====
// Row-wide frame store: one bit per pixel, one row per word, with per-row valid bits.
// Depends on fsfe_pkg for the control struct.
`timescale 1ns / 1ps

module fsfe_frame_store #(
   parameter int SCREEN_WIDTH  = fsfe_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = fsfe_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fsfe_pkg::store_ctl_type     ctl,
   input  logic [SCREEN_WIDTH-1:0]     wr_data,
   output logic [SCREEN_WIDTH-1:0]     rd_data
);

   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] valid_ff;
   logic [SCREEN_WIDTH-1:0]  rd_q_ff;
   logic                     rd_valid_ff;
   logic [ROW_W-1:0]         rd_idx;
   logic [ROW_W-1:0]         wr_idx;

   assign rd_idx = ctl.rd_row[ROW_W-1:0];
   assign wr_idx = ctl.wr_row[ROW_W-1:0];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_idx];
      end
   end

   // A row that was never written since reset or the last clear reads as unlit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.clear) begin
            valid_ff <= '0;
         end else if (ctl.wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// ===== hw/rtl/fsfe_square.sv =====
// Shared squaring unit: one signed distance in, its registered square out.
// Depends on fsfe_pkg for the operand and result widths.
`timescale 1ns / 1ps

module fsfe_square (
   input  logic                               clock,
   input  logic signed [fsfe_pkg::DIST_W-1:0] op,
   output logic        [fsfe_pkg::SQ_W-1:0]   sq
);

   logic signed [2*fsfe_pkg::DIST_W-1:0] prod;
   logic        [fsfe_pkg::SQ_W-1:0]     sq_ff;

   // The operand never reaches -2^13, so the square fits the result width.
   assign prod = op * op;

   always_ff @(posedge clock) begin
      sq_ff <= prod[fsfe_pkg::SQ_W-1:0];
   end

   assign sq = sq_ff;

endmodule

// ===== hw/rtl/framebuffer_shape_fill_engine.sv =====
// Top level of the framebuffer shape fill engine: command sequencer and result register.
// Depends on fsfe_pkg, fsfe_frame_store and fsfe_square.
`timescale 1ns / 1ps

// The engine keeps a one-bit-per-pixel frame of SCREEN_WIDTH columns by SCREEN_HEIGHT
// rows, unlit after reset, and takes one command beat at a time; req_ready is high only
// while the sequencer is idle. Clear drops the per-row valid bits, so there is no
// clearing pass after reset or after a clear. Rectangle does a read and a write of
// each covered row, the box mask being built for the whole row at once. Circle walks
// every pixel through one shared squaring unit: the square of the radius, then per
// row the square of the vertical distance and one horizontal distance per cycle, then
// a row write. Show reads its two rows and then emits SCREEN_WIDTH result beats, one
// per cycle while rsp_ready stays high; the last beat carries rsp_last. The result
// register lets the next command be taken while the final beat of a show is still
// waiting. Rows of a show at or beyond the screen read as unlit, and shapes are
// clipped to the screen.
module framebuffer_shape_fill_engine #(
   parameter int SCREEN_WIDTH  = fsfe_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = fsfe_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_x_first,
   input  logic [5:0]         req_y_first,
   input  logic [5:0]         req_x_last,
   input  logic [5:0]         req_y_last,
   input  logic signed [12:0] req_center_x,
   input  logic signed [12:0] req_center_y,
   input  logic [9:0]         req_radius,
   input  logic [4:0]         req_row_pair,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_char_code,
   output logic [5:0]         rsp_column,
   output logic               rsp_last
);

   localparam int ROW_W = $clog2(SCREEN_HEIGHT);
   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int DW    = fsfe_pkg::DIST_W;
   localparam int SW    = fsfe_pkg::SQ_W;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_RECT_RD  = 13'b0000000000010,
      ST_RECT_WR  = 13'b0000000000100,
      ST_CIR_RR   = 13'b0000000001000,
      ST_CIR_DY   = 13'b0000000010000,
      ST_CIR_DYW  = 13'b0000000100000,
      ST_CIR_DX   = 13'b0000001000000,
      ST_CIR_DXL  = 13'b0000010000000,
      ST_CIR_WR   = 13'b0000100000000,
      ST_SHOW_TOP = 13'b0001000000000,
      ST_SHOW_BOT = 13'b0010000000000,
      ST_SHOW_CAP = 13'b0100000000000,
      ST_SHOW_OUT = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_end_ff;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        pend_col_ff;
   logic                    pend_ff;
   logic [5:0]              x_first_ff;
   logic [5:0]              x_last_ff;
   logic signed [12:0]      center_x_ff;
   logic signed [12:0]      center_y_ff;
   logic [9:0]              radius_ff;
   logic [4:0]              row_pair_ff;
   logic [19:0]             rr_ff;
   logic [SW-1:0]           dy2_ff;
   logic [SCREEN_WIDTH-1:0] mask_ff;
   logic [SCREEN_WIDTH-1:0] top_row_ff;
   logic [SCREEN_WIDTH-1:0] bot_row_ff;
   logic                    rsp_valid_ff;
   logic [6:0]              rsp_char_ff;
   logic [5:0]              rsp_column_ff;
   logic                    rsp_last_ff;

   fsfe_pkg::store_ctl_type store_ctl;
   logic [SCREEN_WIDTH-1:0] store_wr_data;
   logic [SCREEN_WIDTH-1:0] store_rd_data;
   logic [SCREEN_WIDTH-1:0] box_mask;

   logic signed [DW-1:0]    sq_op;
   logic [SW-1:0]           sq;
   logic signed [DW-1:0]    dist_x;
   logic signed [DW-1:0]    dist_y;
   logic                    hit;

   logic                    accept;
   logic                    rect_skip;
   logic                    last_col;
   logic                    last_row;
   logic                    rect_done;
   logic                    rsp_slot_free;
   logic                    top_on_screen;
   logic                    bot_on_screen;
   logic [5:0]              top_row_idx;
   logic [5:0]              bot_row_idx;
   logic [ROW_W-1:0]        rect_row_end;
   logic [6:0]              show_char;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign last_col  = (col_ff == COL_W'(SCREEN_WIDTH - 1));
   assign last_row  = (row_ff == ROW_W'(SCREEN_HEIGHT - 1));
   assign rect_done = (row_ff == row_end_ff);

   // An empty box or one that starts below the screen touches no row at all.
   assign rect_skip = (req_x_last < req_x_first) || (req_y_last < req_y_first) ||
                      ({3'b000, req_y_first} >= 9'(SCREEN_HEIGHT));
   assign rect_row_end = ({3'b000, req_y_last} > 9'(SCREEN_HEIGHT - 1)) ?
                         ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(req_y_last);

   always_comb begin
      for (int c = 0; c < SCREEN_WIDTH; c++) begin
         box_mask[c] = (9'(c) >= {3'b000, x_first_ff}) && (9'(c) <= {3'b000, x_last_ff});
      end
   end

   // Distances from the pixel center (16 * index + 8) to the circle center.
   assign dist_x = $signed({center_x_ff[12], center_x_ff}) -
                   $signed(DW'({col_ff, 4'b1000}));
   assign dist_y = $signed({center_y_ff[12], center_y_ff}) -
                   $signed(DW'({row_ff, 4'b1000}));

   always_comb begin
      case (state_ff)
         ST_CIR_RR: sq_op = $signed({4'b0000, radius_ff});
         ST_CIR_DY: sq_op = dist_y;
         default:   sq_op = dist_x;
      endcase
   end

   fsfe_square u_square (
      .clock (clock),
      .op    (sq_op),
      .sq    (sq)
   );

   assign hit = ({1'b0, sq} + {1'b0, dy2_ff}) <= (SW + 1)'(rr_ff);

   assign top_row_idx   = {row_pair_ff, 1'b0};
   assign bot_row_idx   = {row_pair_ff, 1'b1};
   assign top_on_screen = {3'b000, top_row_idx} < 9'(SCREEN_HEIGHT);
   assign bot_on_screen = {3'b000, bot_row_idx} < 9'(SCREEN_HEIGHT);

   // Frame store accesses: a read always precedes the write of the same row.
   always_comb begin
      store_ctl.rd_en  = 1'b0;
      store_ctl.rd_row = fsfe_pkg::ROW_ADDR_W'(row_ff);
      store_ctl.wr_en  = 1'b0;
      store_ctl.wr_row = fsfe_pkg::ROW_ADDR_W'(row_ff);
      store_ctl.clear  = accept && (req_command == fsfe_pkg::CMD_CLEAR);
      store_wr_data    = store_rd_data | mask_ff;
      case (state_ff)
         ST_RECT_RD: store_ctl.rd_en = 1'b1;
         ST_CIR_DY:  store_ctl.rd_en = 1'b1;
         ST_RECT_WR: begin
            store_ctl.wr_en = 1'b1;
            store_wr_data   = store_rd_data | box_mask;
         end
         ST_CIR_WR:  store_ctl.wr_en = 1'b1;
         ST_SHOW_TOP: begin
            store_ctl.rd_en  = 1'b1;
            store_ctl.rd_row = fsfe_pkg::ROW_ADDR_W'(ROW_W'(top_row_idx));
         end
         ST_SHOW_BOT: begin
            store_ctl.rd_en  = 1'b1;
            store_ctl.rd_row = fsfe_pkg::ROW_ADDR_W'(ROW_W'(bot_row_idx));
         end
         default: ;
      endcase
   end

   fsfe_frame_store #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_frame_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_data (store_wr_data),
      .rd_data (store_rd_data)
   );

   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case ({top_row_ff[col_ff], bot_row_ff[col_ff]})
         2'b11:   show_char = fsfe_pkg::CHAR_BOTH;
         2'b10:   show_char = fsfe_pkg::CHAR_TOP;
         2'b01:   show_char = fsfe_pkg::CHAR_BOTTOM;
         default: show_char = fsfe_pkg::CHAR_NONE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  fsfe_pkg::CMD_RECT:   state_in = rect_skip ? ST_IDLE : ST_RECT_RD;
                  fsfe_pkg::CMD_CIRCLE: state_in = ST_CIR_RR;
                  fsfe_pkg::CMD_SHOW:   state_in = ST_SHOW_TOP;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_RECT_RD:  state_in = ST_RECT_WR;
         ST_RECT_WR:  state_in = rect_done ? ST_IDLE : ST_RECT_RD;
         ST_CIR_RR:   state_in = ST_CIR_DY;
         ST_CIR_DY:   state_in = ST_CIR_DYW;
         ST_CIR_DYW:  state_in = ST_CIR_DX;
         ST_CIR_DX:   state_in = last_col ? ST_CIR_DXL : ST_CIR_DX;
         ST_CIR_DXL:  state_in = ST_CIR_WR;
         ST_CIR_WR:   state_in = last_row ? ST_IDLE : ST_CIR_DY;
         ST_SHOW_TOP: state_in = ST_SHOW_BOT;
         ST_SHOW_BOT: state_in = ST_SHOW_CAP;
         ST_SHOW_CAP: state_in = ST_SHOW_OUT;
         ST_SHOW_OUT: state_in = (rsp_slot_free && last_col) ? ST_IDLE : ST_SHOW_OUT;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == ST_CIR_DX);
         if ((state_ff == ST_SHOW_OUT) && rsp_slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers; none of them needs a reset value.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_first_ff  <= req_x_first;
         x_last_ff   <= req_x_last;
         center_x_ff <= req_center_x;
         center_y_ff <= req_center_y;
         radius_ff   <= req_radius;
         row_pair_ff <= req_row_pair;
         row_end_ff  <= rect_row_end;
         row_ff      <= (req_command == fsfe_pkg::CMD_RECT) ? ROW_W'(req_y_first) : '0;
      end

      // Each square comes back in the cycle after its distance went in.
      if (pend_ff) begin
         mask_ff[pend_col_ff] <= hit;
      end
      pend_col_ff <= col_ff;

      case (state_ff)
         ST_RECT_WR: row_ff <= row_ff + ROW_W'(1);
         ST_CIR_DY: begin
            // The radius square is only in the unit's output on the first row.
            if (row_ff == '0) begin
               rr_ff <= sq[19:0];
            end
            mask_ff <= '0;
         end
         ST_CIR_DYW: begin
            dy2_ff <= sq;
            col_ff <= '0;
         end
         ST_CIR_DX:  col_ff <= col_ff + COL_W'(1);
         ST_CIR_WR:  row_ff <= row_ff + ROW_W'(1);
         ST_SHOW_BOT: top_row_ff <= top_on_screen ? store_rd_data : '0;
         ST_SHOW_CAP: begin
            bot_row_ff <= bot_on_screen ? store_rd_data : '0;
            col_ff     <= '0;
         end
         ST_SHOW_OUT: begin
            if (rsp_slot_free) begin
               rsp_char_ff   <= show_char;
               rsp_column_ff <= 6'(col_ff);
               rsp_last_ff   <= last_col;
               col_ff        <= col_ff + COL_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_last      = rsp_last_ff;

   // The store has one access per cycle: never a read and a write together.
   a_store_single_access: assert property (@(posedge clock) disable iff (reset)
      !(store_ctl.rd_en && store_ctl.wr_en))
      else $error("frame store read and written in the same cycle");

   // A clear only happens while no drawing sequence is in flight.
   a_clear_when_idle: assert property (@(posedge clock) disable iff (reset)
      store_ctl.clear |-> (state_ff == ST_IDLE))
      else $error("clear issued outside idle");

   // A circle row is written only after its last pixel result has landed in the mask.
   a_circle_mask_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CIR_WR) |-> !pend_ff)
      else $error("circle row written with a pixel result pending");

   // The final beat of a show is always the rightmost column.
   a_last_on_final_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_column == 6'(SCREEN_WIDTH - 1)))
      else $error("last flag on a column other than the final one");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for framebuffer_shape_fill_engine: random and directed commands
// against a behavioral copy of the frame store. Depends on fsfe_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int SCREEN_W = fsfe_pkg::SCREEN_WIDTH_DEFAULT;
   localparam int SCREEN_H = fsfe_pkg::SCREEN_HEIGHT_DEFAULT;

   // One command beat as the sender holds it on the req_ ports.
   typedef struct {
      logic [1:0]         command;
      logic [5:0]         x_first;
      logic [5:0]         y_first;
      logic [5:0]         x_last;
      logic [5:0]         y_last;
      logic signed [12:0] center_x;
      logic signed [12:0] center_y;
      logic [9:0]         radius;
      logic [4:0]         row_pair;
   } command_beat_type;

   // One character beat as the engine presents it on the rsp_ ports.
   typedef struct {
      logic [6:0] char_code;
      logic [5:0] column;
      logic       last;
   } char_beat_type;

   // The scoreboard keeps its own copy of the pixel array. Every accepted command is
   // applied to that copy at once; a show turns the two addressed rows into the queue of
   // characters the engine must later produce, in column order.
   class fill_scoreboard;
      bit            lit [SCREEN_H][SCREEN_W];
      char_beat_type pending_chars [$];
      int            errors;

      function new();
         errors = 0;
         wipe_frame();
      endfunction

      function void wipe_frame();
         for (int y = 0; y < SCREEN_H; y++)
            for (int x = 0; x < SCREEN_W; x++)
               lit[y][x] = 1'b0;
      endfunction

      function void note_request(command_beat_type cb);
         longint        r2, dx, dy;
         int            top_row, bottom_row;
         bit            t, b;
         char_beat_type cbeat;
         case (cb.command)
            fsfe_pkg::CMD_CLEAR: wipe_frame();
            fsfe_pkg::CMD_RECT: begin
               // An inverted corner pair describes an empty box; the loops simply
               // never run in that case. Fields cannot leave a 64 by 64 screen.
               for (int y = cb.y_first; y <= cb.y_last && y < SCREEN_H; y++)
                  for (int x = cb.x_first; x <= cb.x_last && x < SCREEN_W; x++)
                     lit[y][x] = 1'b1;
            end
            fsfe_pkg::CMD_CIRCLE: begin
               // Pixel centers sit at 16*n + 8 in sixteenths; the test is exact.
               r2 = longint'(cb.radius) * longint'(cb.radius);
               for (int y = 0; y < SCREEN_H; y++) begin
                  dy = longint'(cb.center_y) - longint'(16 * y + 8);
                  for (int x = 0; x < SCREEN_W; x++) begin
                     dx = longint'(cb.center_x) - longint'(16 * x + 8);
                     if (dx * dx + dy * dy <= r2)
                        lit[y][x] = 1'b1;
                  end
               end
            end
            default: begin
               top_row    = 2 * int'(cb.row_pair);
               bottom_row = top_row + 1;
               for (int x = 0; x < SCREEN_W; x++) begin
                  t = (top_row < SCREEN_H) ? lit[top_row][x] : 1'b0;
                  b = (bottom_row < SCREEN_H) ? lit[bottom_row][x] : 1'b0;
                  if (t && b)
                     cbeat.char_code = fsfe_pkg::CHAR_BOTH;
                  else if (t)
                     cbeat.char_code = fsfe_pkg::CHAR_TOP;
                  else if (b)
                     cbeat.char_code = fsfe_pkg::CHAR_BOTTOM;
                  else
                     cbeat.char_code = fsfe_pkg::CHAR_NONE;
                  cbeat.column = x[5:0];
                  cbeat.last   = (x == SCREEN_W - 1);
                  pending_chars.push_back(cbeat);
               end
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_result(logic [6:0] char_code, logic [5:0] column, logic last);
         char_beat_type want;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected beat char 0x%h column %0d", char_code, column));
            return;
         end
         want = pending_chars.pop_front();
         if (char_code !== want.char_code)
            report($sformatf("column %0d char 0x%h, expected 0x%h",
                             want.column, char_code, want.char_code));
         if (column !== want.column)
            report($sformatf("column %0d, expected %0d", column, want.column));
         if (last !== want.last)
            report($sformatf("column %0d last %b, expected %b",
                             want.column, last, want.last));
      endtask

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = fsfe_pkg::CMD_CLEAR;
   logic [5:0]         req_x_first = '0;
   logic [5:0]         req_y_first = '0;
   logic [5:0]         req_x_last = '0;
   logic [5:0]         req_y_last = '0;
   logic signed [12:0] req_center_x = '0;
   logic signed [12:0] req_center_y = '0;
   logic [9:0]         req_radius = '0;
   logic [4:0]         req_row_pair = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [6:0]         rsp_char_code;
   logic [5:0]         rsp_column;
   logic               rsp_last;

   // Set by the stimulus: steady_flow turns off random idling on both sides, and
   // hold_wanted asks the result sink for its one long stall.
   bit steady_flow = 1'b0;
   bit hold_wanted = 1'b0;

   fill_scoreboard sb = new();

   framebuffer_shape_fill_engine dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_x_first   (req_x_first),
      .req_y_first   (req_y_first),
      .req_x_last    (req_x_last),
      .req_y_last    (req_y_last),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_row_pair  (req_row_pair),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_column    (rsp_column),
      .rsp_last      (rsp_last)
   );

   always #5 clock = ~clock;

   // Every field gets random content, including the ones the command ignores, so
   // that unused bits toggle and cannot leak into the result.
   function automatic command_beat_type noisy_beat(logic [1:0] command);
      command_beat_type cb;
      cb.command  = command;
      cb.x_first  = 6'($urandom);
      cb.y_first  = 6'($urandom);
      cb.x_last   = 6'($urandom);
      cb.y_last   = 6'($urandom);
      cb.center_x = 13'($urandom);
      cb.center_y = 13'($urandom);
      cb.radius   = 10'($urandom);
      cb.row_pair = 5'($urandom);
      return cb;
   endfunction

   // Random command mix. Circles are kept to about one in seven since each one walks
   // the whole screen pixel by pixel.
   function automatic command_beat_type random_beat();
      command_beat_type cb;
      int               pick;
      logic [5:0]       swap;
      pick = $urandom_range(0, 99);
      if (pick < 7)
         cb = noisy_beat(fsfe_pkg::CMD_CLEAR);
      else if (pick < 45)
         cb = noisy_beat(fsfe_pkg::CMD_RECT);
      else if (pick < 60)
         cb = noisy_beat(fsfe_pkg::CMD_CIRCLE);
      else
         cb = noisy_beat(fsfe_pkg::CMD_SHOW);
      if (cb.command == fsfe_pkg::CMD_RECT && $urandom_range(0, 99) < 80) begin
         // Mostly well-ordered boxes, often small ones, so the frame does not saturate.
         if (cb.x_last < cb.x_first) begin
            swap = cb.x_first; cb.x_first = cb.x_last; cb.x_last = swap;
         end
         if (cb.y_last < cb.y_first) begin
            swap = cb.y_first; cb.y_first = cb.y_last; cb.y_last = swap;
         end
         if ($urandom_range(0, 1)) begin
            if (cb.x_last - cb.x_first > 12)
               cb.x_last = cb.x_first + 6'($urandom_range(0, 12));
            if (cb.y_last - cb.y_first > 12)
               cb.y_last = cb.y_first + 6'($urandom_range(0, 12));
         end
      end
      if (cb.command == fsfe_pkg::CMD_CIRCLE && $urandom_range(0, 99) < 75) begin
         // Centers near the screen and moderate radii give partly visible discs;
         // the rest keep the fully random 13-bit centers and 10-bit radii.
         cb.center_x = 13'($urandom_range(0, 1280) - 128);
         cb.center_y = 13'($urandom_range(0, 1280) - 128);
         cb.radius   = 10'($urandom_range(0, 320));
      end
      return cb;
   endfunction

   // Offers one command beat and returns at the rising edge that accepts it. It is
   // entered at a rising edge, so the payload changes only at clock edges. The ready
   // check happens at the falling edge, where both sides of the handshake are settled,
   // and holds for the rising edge that follows.
   task automatic send_command(command_beat_type cb);
      if (!steady_flow && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cb.command;
      req_x_first  <= cb.x_first;
      req_y_first  <= cb.y_first;
      req_x_last   <= cb.x_last;
      req_y_last   <= cb.y_last;
      req_center_x <= cb.center_x;
      req_center_y <= cb.center_y;
      req_radius   <= cb.radius;
      req_row_pair <= cb.row_pair;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sb.note_request(cb);
   endtask

   task automatic send_rect(int x0, int y0, int x1, int y1);
      command_beat_type cb;
      cb = noisy_beat(fsfe_pkg::CMD_RECT);
      cb.x_first = 6'(x0);
      cb.y_first = 6'(y0);
      cb.x_last  = 6'(x1);
      cb.y_last  = 6'(y1);
      send_command(cb);
   endtask

   task automatic send_circle(int cx, int cy, int r);
      command_beat_type cb;
      cb = noisy_beat(fsfe_pkg::CMD_CIRCLE);
      cb.center_x = 13'(cx);
      cb.center_y = 13'(cy);
      cb.radius   = 10'(r);
      send_command(cb);
   endtask

   task automatic send_show(int pair);
      command_beat_type cb;
      cb = noisy_beat(fsfe_pkg::CMD_SHOW);
      cb.row_pair = 5'(pair);
      send_command(cb);
   endtask

   // Result sink. Beats are checked at the falling edge before the rising edge that
   // takes them; rsp_ready changes only at rising edges. It idles at random, not at
   // all during the steady window, and once stalls while the sender keeps offering
   // shows, so the engine backs up into its command port.
   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_char_code, rsp_column, rsp_last);
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 10);
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      command_beat_type cb;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A fresh frame must show blank, a full box solid, and the
      // corners, empty boxes and discs below each leave a distinct mark.
      send_show(0);
      send_rect(0, 0, 63, 63);
      send_show(0);
      send_show(31);
      send_command(noisy_beat(fsfe_pkg::CMD_CLEAR));
      send_show(31);
      send_rect(5, 3, 4, 9);                // right edge left of the left edge: empty
      send_rect(2, 9, 7, 8);                // bottom above the top: empty
      send_rect(63, 63, 63, 63);            // single pixel in the far corner
      send_rect(10, 0, 20, 0);              // one row on top
      send_show(0);
      send_show(31);
      send_circle(8, 8, 0);                 // zero radius exactly on a pixel center
      send_circle(9, 24, 0);                // zero radius off center: nothing lit
      send_show(0);
      send_circle(-2048, -2048, 1023);      // entirely off screen
      send_circle(-4096, 4095, 1023);       // field extremes, off screen
      send_circle(-100, -100, 400);         // clipped at the top left
      send_circle(1100, 1100, 300);         // clipped at the bottom right
      send_show(1);
      send_show(30);
      send_command(noisy_beat(fsfe_pkg::CMD_CLEAR));
      send_circle(512, 512, 1023);          // largest radius over the middle
      send_show(16);

      // Random part, with one window of steady flow and, earlier, the long result
      // stall with a run of shows behind it.
      for (int n = 0; n < 270; n++) begin
         steady_flow = (n >= 140 && n < 200);
         if (n == 60)
            hold_wanted = 1'b1;
         if (n >= 60 && n < 66)
            cb = noisy_beat(fsfe_pkg::CMD_SHOW);
         else
            cb = random_beat();
         send_command(cb);
      end
      steady_flow = 1'b0;
      send_show(int'($urandom_range(0, 31)));
      req_valid <= 1'b0;

      while (sb.pending() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: a correct run ends far sooner even if every command were a circle.
   initial begin : watchdog
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
